FILE: rtl/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ULK_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ulk check failed");

// next-cycle implication
`define ULK_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ulk check failed");

`endif

FILE: rtl/ulk_pkg.sv
package ulk_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam int KEY_W = 32;
	localparam int POS_W = 6;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [2:0] {
		REQ_INSERT    = 3'd0,
		REQ_DELETE    = 3'd1,
		REQ_FIND      = 3'd2,
		REQ_GET_NEXT  = 3'd3,
		REQ_CLEAR     = 3'd4,
		REQ_RESET_CUR = 3'd5
	} req_code_t;

	typedef enum logic [2:0] {
		STS_OK    = 3'd0,
		STS_DUP   = 3'd1,
		STS_MISS  = 3'd2,
		STS_FULL  = 3'd3,
		STS_EMPTY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_GNEXT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic                 found;
		logic [POS_W-1:0]     position;
		logic [KEY_W-1:0]     key_out;
		logic [CNT_OUT_W-1:0] count;
		logic [2:0]           status;
	} rsp_t;

endpackage

FILE: rtl/ulk_ram.sv
module ulk_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/unique_key_list_engine_core.sv
// channel | valid     | stall     | payload      | direction
// request | req_valid | req_stall | req (req_t)  | in
// result  | rsp_valid | rsp_stall | rsp (rsp_t)  | out
//
// Insert/delete/find scan the list through the one RAM read port, one entry a cycle;
// delete goes on from the hit with a shift of the tail, one entry a cycle. Get next
// reads the cursor entry in S_GNEXT; clear and cursor reset go straight to S_FIN.
// One request at a time: req_stall is high from acceptance until the result is loaded.
// Reset clears the control state, count and cursor but not the RAM; entries past the count are never used.
// A result waits in the output register while rsp_stall is high.
module unique_key_list_engine_core
	import ulk_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t              state_q, state_d;
	logic [2:0]          op_q, op_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [IDX_W-1:0]    cur_q, cur_d;
	logic [CNT_W-1:0]    scan_q, scan_d;
	logic                pend_s1, pend_d;
	logic [CNT_W-1:0]    pidx_s1, pidx_d;
	rsp_t                res_q, res_d;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic                rsp_load;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;

	logic                issue;
	logic                hit;
	logic [CNT_W-1:0]    dst;
	logic [CNT_W-1:0]    cur_eff;
	logic [CNT_W-1:0]    cur_nxt;
	logic [KEY_BITS-1:0] key_in;
	logic                out_free;

	ulk_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(KEY_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign key_in   = KEY_BITS'(req.key);
	assign issue    = (scan_q < cnt_q);
	assign hit      = pend_s1 && (ram_rdata == key_q);
	assign dst      = pidx_s1 - CNT_W'(1);
	assign cur_eff  = (CNT_W'(cur_q) >= cnt_q) ? '0 : CNT_W'(cur_q);
	assign cur_nxt  = CNT_W'(cur_q) + CNT_W'(1);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		key_d     = key_q;
		cnt_d     = cnt_q;
		cur_d     = cur_q;
		scan_d    = scan_q;
		pend_d    = 1'b0;
		pidx_d    = scan_q;
		res_d     = res_q;
		rsp_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IDX_W-1:0];
		ram_wdata = key_q;
		ram_raddr = scan_q[IDX_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d         = req.req_type;
					key_d        = key_in;
					res_d        = '0;
					res_d.count  = CNT_OUT_W'(cnt_q);
					res_d.status = STS_OK;
					state_d      = S_FIN;
					unique case (req.req_type) inside
						REQ_INSERT, REQ_DELETE, REQ_FIND: begin
							if (cnt_q == '0) begin
								if (req.req_type == REQ_INSERT) begin
									// empty list: append at slot 0 directly
									ram_we      = 1'b1;
									ram_waddr   = '0;
									ram_wdata   = key_in;
									cnt_d       = CNT_W'(1);
									res_d.count = CNT_OUT_W'(1);
								end else begin
									res_d.status = STS_MISS;
								end
							end else begin
								scan_d  = '0;
								state_d = S_SEARCH;
							end
						end
						REQ_GET_NEXT: begin
							if (cnt_q == '0) begin
								res_d.status = STS_EMPTY;
							end else begin
								// stale cursor restarts at entry 0
								ram_raddr = cur_eff[IDX_W-1:0];
								cur_d     = cur_eff[IDX_W-1:0];
								state_d   = S_GNEXT;
							end
						end
						REQ_CLEAR: begin
							cnt_d       = '0;
							res_d.count = '0;
						end
						REQ_RESET_CUR: begin
							cur_d = '0;
						end
						default: begin
						end
					endcase
				end
			end

			S_SEARCH: begin
				// read at scan_q, compare the word read the cycle before
				pend_d = issue;
				if (issue) begin
					scan_d = scan_q + CNT_W'(1);
				end
				if (hit) begin
					res_d.found    = 1'b1;
					res_d.position = POS_W'(pidx_s1);
					res_d.key_out  = KEY_W'(ram_rdata);
					pend_d         = 1'b0;
					if (op_q == REQ_DELETE) begin
						scan_d  = pidx_s1 + CNT_W'(1);
						state_d = S_SHIFT;
					end else begin
						res_d.status = (op_q == REQ_INSERT) ? STS_DUP : STS_OK;
						state_d      = S_FIN;
					end
				end else if (!pend_s1 && !issue) begin
					state_d = S_FIN;
					if (op_q == REQ_INSERT) begin
						if (cnt_q >= CNT_W'(CAPACITY)) begin
							res_d.status = STS_FULL;
						end else begin
							ram_we         = 1'b1;
							res_d.position = POS_W'(cnt_q);
							cnt_d          = cnt_q + CNT_W'(1);
							res_d.count    = CNT_OUT_W'(cnt_q + CNT_W'(1));
						end
					end else begin
						res_d.status = STS_MISS;
					end
				end
			end

			S_SHIFT: begin
				// entry i+1 read one cycle, written to i the next
				pend_d = issue;
				if (issue) begin
					scan_d = scan_q + CNT_W'(1);
				end
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = dst[IDX_W-1:0];
					ram_wdata = ram_rdata;
				end
				if (!pend_s1 && !issue) begin
					cnt_d       = cnt_q - CNT_W'(1);
					res_d.count = CNT_OUT_W'(cnt_q - CNT_W'(1));
					state_d     = S_FIN;
				end
			end

			S_GNEXT: begin
				res_d.found    = 1'b1;
				res_d.position = POS_W'(cur_q);
				res_d.key_out  = KEY_W'(ram_rdata);
				cur_d          = (cur_nxt >= cnt_q) ? '0 : cur_nxt[IDX_W-1:0];
				state_d        = S_FIN;
			end

			S_FIN: begin
				if (out_free) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cur_q       <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			cur_q   <= cur_d;
			scan_q  <= scan_d;
			pend_s1 <= pend_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		key_q   <= key_d;
		pidx_s1 <= pidx_d;
		res_q   <= res_d;
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

endmodule

FILE: rtl/ulk_chk.sv
`include "assert_macros.svh"

module ulk_chk
	import ulk_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	`ULK_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`ULK_ASSERT_IMP(a_dup_found, clk, arst_n, rsp_valid && rsp.status == STS_DUP, rsp.found)
	`ULK_ASSERT_IMP(a_miss_key, clk, arst_n, rsp_valid && !rsp.found, rsp.key_out == '0)
	`ULK_ASSERT_NXT(a_busy, clk, arst_n, req_valid && !req_stall, req_stall)

endmodule

bind unique_key_list_engine_core ulk_chk u_ulk_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import ulk_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int POOL_SIZE = 96;
	// request codes the block has no meaning for
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// expected list contents, length and round-robin cursor
	logic [KEY_W-1:0] list_keys [CAP];
	int list_len = 0;
	int rr_cursor = 0;

	rsp_t pending [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	bit calm = 1'b0;
	int fail_count = 0;
	int sent = 0;
	int checked = 0;
	int status_seen [5] = '{default: 0};

	unique_key_list_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #10 clk = ~clk;

	initial begin
		#50_000_000;
		$display("tb: failure");
		$finish;
	end

	// expected result of one request; updates the list state
	function automatic rsp_t list_result(input req_t item);
		rsp_t r;
		int hit;
		r = '0;
		hit = -1;
		for (int i = list_len - 1; i >= 0; i--)
			if (list_keys[i] == item.key)
				hit = i;
		case (item.req_type)
		REQ_INSERT: begin
			if (hit >= 0) begin
				r.found = 1'b1;
				r.position = hit[POS_W-1:0];
				r.key_out = list_keys[hit];
				r.status = STS_DUP;
			end else if (list_len >= CAP) begin
				r.status = STS_FULL;
			end else begin
				list_keys[list_len] = item.key;
				r.position = list_len[POS_W-1:0];
				list_len++;
			end
		end
		REQ_DELETE, REQ_FIND: begin
			if (hit < 0) begin
				r.status = STS_MISS;
			end else begin
				r.found = 1'b1;
				r.position = hit[POS_W-1:0];
				r.key_out = list_keys[hit];
				if (item.req_type == REQ_DELETE) begin
					for (int i = hit; i < list_len - 1; i++)
						list_keys[i] = list_keys[i + 1];
					list_len--;
				end
			end
		end
		REQ_GET_NEXT: begin
			if (list_len == 0) begin
				r.status = STS_EMPTY;
			end else begin
				// stale cursor after delete or clear restarts at the head
				if (rr_cursor >= list_len)
					rr_cursor = 0;
				r.found = 1'b1;
				r.position = rr_cursor[POS_W-1:0];
				r.key_out = list_keys[rr_cursor];
				rr_cursor = (rr_cursor + 1 >= list_len) ? 0 : rr_cursor + 1;
			end
		end
		REQ_CLEAR: list_len = 0;
		REQ_RESET_CUR: rr_cursor = 0;
		default: ;
		endcase
		r.count = list_len[CNT_OUT_W-1:0];
		status_seen[r.status]++;
		return r;
	endfunction

	task automatic send_req(input logic [2:0] op, input logic [KEY_W-1:0] k);
		req_t item;
		item.req_type = op;
		item.key = k;
		while (!calm && $urandom_range(0, 99) < 11) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		pending.push_back(list_result(item));
		sent++;
	endtask

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("tb: %s", msg);
	endtask

	always @(posedge clk)
		rsp_stall <= !calm && ($urandom_range(0, 99) < 11);

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending.size() == 0) begin
				report_fail($sformatf("result with nothing expected: %p", rsp));
			end else begin
				want = pending.pop_front();
				if (rsp.found !== want.found || rsp.position !== want.position ||
						rsp.key_out !== want.key_out || rsp.count !== want.count ||
						rsp.status !== want.status)
					report_fail($sformatf({"result %0d: exp found=%0d pos=%0d key=%h ",
						"cnt=%0d st=%0d, got found=%0d pos=%0d key=%h cnt=%0d st=%0d"},
						checked, want.found, want.position, want.key_out, want.count,
						want.status, rsp.found, rsp.position, rsp.key_out, rsp.count,
						rsp.status));
			end
			checked++;
		end
	end

	// empty list, extreme keys, duplicates, wrap, shifts, stale cursor, clear
	task automatic test_directed();
		send_req(REQ_GET_NEXT, '0);
		send_req(REQ_FIND, '0);
		send_req(REQ_DELETE, 32'd5);
		send_req(REQ_INSERT, '0);
		send_req(REQ_INSERT, '1);
		send_req(REQ_INSERT, '0);
		send_req(REQ_FIND, '1);
		repeat (3) send_req(REQ_GET_NEXT, '0);
		send_req(REQ_INSERT, 32'h8000_0001);
		send_req(REQ_INSERT, 32'h7fff_fffe);
		send_req(REQ_DELETE, '0);
		send_req(REQ_GET_NEXT, '0);
		send_req(REQ_DELETE, 32'h7fff_fffe);
		send_req(REQ_GET_NEXT, '0);
		send_req(REQ_RESET_CUR, '1);
		send_req(REQ_GET_NEXT, '0);
		send_req(REQ_CLEAR, '0);
		send_req(REQ_GET_NEXT, '0);
		send_req(REQ_FIND, '1);
		send_req(REQ_INSERT, 32'h1234_5678);
		send_req(REQ_GET_NEXT, '0);
		send_req(REQ_SPARE_6, '1);
		send_req(REQ_SPARE_7, 32'h5555_aaaa);
	endtask

	// back-to-back fill to capacity, overflow, full wrap; then drain in random order with gaps
	task automatic test_fill_drain();
		logic [KEY_W-1:0] live [$];
		logic [KEY_W-1:0] k;
		int j;
		calm = 1'b1;
		send_req(REQ_CLEAR, '0);
		send_req(REQ_RESET_CUR, '0);
		for (int i = 0; i < CAP; i++) begin
			k = $urandom();
			k[KEY_W-1 -: 8] = i[7:0];
			live.push_back(k);
			send_req(REQ_INSERT, k);
		end
		send_req(REQ_INSERT, 32'hff00_0000);
		send_req(REQ_INSERT, live[CAP - 1]);
		send_req(REQ_FIND, live[0]);
		send_req(REQ_FIND, live[CAP - 1]);
		repeat (CAP + 6) send_req(REQ_GET_NEXT, '0);
		calm = 1'b0;
		while (live.size() != 0) begin
			j = $urandom_range(0, live.size() - 1);
			send_req(REQ_DELETE, live[j]);
			live.delete(j);
			if ($urandom_range(0, 2) == 0)
				send_req(REQ_GET_NEXT, '0);
		end
		send_req(REQ_GET_NEXT, '0);
	endtask

	// mixed traffic over a key pool small enough to hit, fill and overflow
	task automatic test_random_mix(input int n);
		int pick;
		logic [2:0] op;
		logic [KEY_W-1:0] k;
		foreach (key_pool[i])
			key_pool[i] = $urandom();
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 34)
				op = REQ_INSERT;
			else if (pick < 54)
				op = REQ_DELETE;
			else if (pick < 72)
				op = REQ_FIND;
			else if (pick < 89)
				op = REQ_GET_NEXT;
			else if (pick < 92)
				op = REQ_CLEAR;
			else if (pick < 96)
				op = REQ_RESET_CUR;
			else if (pick < 98)
				op = REQ_SPARE_6;
			else
				op = REQ_SPARE_7;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = $urandom();
			send_req(op, k);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_drain();
		test_random_mix(1450);
		req_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (2 * CAP + 10) @(posedge clk);
		$display("tb: %0d requests, %0d results checked, %0d mismatches",
			sent, checked, fail_count);
		$display("tb: outcomes ok=%0d duplicate=%0d miss=%0d full=%0d empty=%0d",
			status_seen[STS_OK], status_seen[STS_DUP], status_seen[STS_MISS],
			status_seen[STS_FULL], status_seen[STS_EMPTY]);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/ulk_pkg.sv
rtl/ulk_ram.sv
rtl/unique_key_list_engine_core.sv
rtl/ulk_chk.sv
tb/tb.sv
